FILE: sv/assert_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, held off during reset.
`define ITP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("itp: same-cycle check failed");

// Next-cycle implication, sampled on clock, held off during reset.
`define ITP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("itp: next-cycle check failed");

`endif

FILE: sv/itp_pkg.sv
// Operator codes, result kinds and character helpers for the infix to postfix converter.
package itp_pkg;

   typedef logic [2:0] op_code_type;
   typedef logic [2:0] kind_type;
   typedef logic [1:0] prec_type;

   localparam op_code_type OP_OPEN  = 3'd0;
   localparam op_code_type OP_PLUS  = 3'd1;
   localparam op_code_type OP_MINUS = 3'd2;
   localparam op_code_type OP_MUL   = 3'd3;
   localparam op_code_type OP_DIV   = 3'd4;
   localparam op_code_type OP_POW   = 3'd5;

   localparam kind_type KIND_CHAR     = 3'd0;
   localparam kind_type KIND_END      = 3'd1;
   localparam kind_type KIND_BAD      = 3'd2;
   localparam kind_type KIND_CLOSE    = 3'd3;
   localparam kind_type KIND_OPEN     = 3'd4;
   localparam kind_type KIND_OVERFLOW = 3'd5;

   localparam logic [7:0] CH_NONE  = 8'h00;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_POW   = 8'h5E;

   // OP_OPEN doubles as "not an operator".
   function automatic op_code_type op_of_char(input logic [7:0] c);
      op_code_type code;
      case (c)
         CH_PLUS:  code = OP_PLUS;
         CH_MINUS: code = OP_MINUS;
         CH_MUL:   code = OP_MUL;
         CH_DIV:   code = OP_DIV;
         CH_POW:   code = OP_POW;
         default:  code = OP_OPEN;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] char_of_op(input op_code_type code);
      logic [7:0] c;
      case (code)
         OP_OPEN:  c = CH_OPEN;
         OP_PLUS:  c = CH_PLUS;
         OP_MINUS: c = CH_MINUS;
         OP_MUL:   c = CH_MUL;
         OP_DIV:   c = CH_DIV;
         OP_POW:   c = CH_POW;
         default:  c = CH_NONE;
      endcase
      return c;
   endfunction

   function automatic prec_type prec_of_op(input op_code_type code);
      prec_type p;
      case (code)
         OP_PLUS, OP_MINUS: p = 2'd1;
         OP_MUL, OP_DIV:    p = 2'd2;
         OP_POW:            p = 2'd3;
         default:           p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

endpackage

FILE: sv/itp_intf.sv
// Valid/ready channel interfaces for expression characters and postfix results.
interface itp_char_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       final_item;

   modport source (output valid, character, final_item, input ready);
   modport sink   (input valid, character, final_item, output ready);
endinterface

interface itp_rslt_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_character;
   logic [2:0] kind;
   logic       last_of_run;

   modport source (output valid, out_character, kind, last_of_run, input ready);
   modport sink   (input valid, out_character, kind, last_of_run, output ready);
endinterface

FILE: sv/itp_stack_mem.sv
// Operator stack storage: one write port, one read port with registered data.
module itp_stack_mem
   import itp_pkg::*;
#(
   parameter int  DEPTH  = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  op_code_type       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output op_code_type       rd_data
);

   op_code_type mem [DEPTH];
   op_code_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/infix_to_postfix_converter_unit.sv
// Infix to postfix converter top level: sequencer, top-of-stack register and output stage.
//
// Feed an infix expression one ASCII character per word on req_if, with final_item set on
// the last word (character 0 on a final word just ends the expression). Letters and digits
// come straight back on rsp_if as postfix words; the operators + - * / ^ (all left
// associative, ^ highest) and parentheses go through an operator stack held in a
// synchronous RAM of STACK_DEPTH entries (one write port, one read port), with the top
// entry cached in a register. The final word also yields an end word, or an error word (bad
// character, unmatched ')', unmatched '(', stack overflow); after a mid-expression error the
// rest of the expression is swallowed without results up to and including its final word.
// last_of_run marks the last result of each input word. One word is worked on at a time;
// each operator popped off the stack is emitted, then a RAM read refills the top register,
// also when the expression is closed at a final word. A word is accepted while the previous
// result still waits in the output register; a stalled sink holds the decode and pop steps
// whenever a result is held back and the output register is still full. No clearing pass is
// needed after reset: a stack entry is used only after it was pushed.
`include "assert_macros.svh"

module infix_to_postfix_converter_unit
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input logic        clock,
   input logic        reset,
   itp_char_if.sink   req_if,
   itp_rslt_if.source rsp_if
);

   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = $clog2(STACK_DEPTH);

   localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);
   localparam logic [DEPTH_W-1:0] DEPTH_ONE  = DEPTH_W'(1);
   localparam logic [DEPTH_W-1:0] DEPTH_TWO  = DEPTH_W'(2);

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;  // take a word, drain the held result
   localparam logic [2:0] S_DECODE = 3'd1;  // classify the word
   localparam logic [2:0] S_OPPOP  = 3'd2;  // pop operators of equal or higher precedence
   localparam logic [2:0] S_POP    = 3'd3;  // pop down to a '('
   localparam logic [2:0] S_WAIT   = 3'd4;  // refill the top register from RAM

   logic [2:0]         state_ff, state_in;
   logic [2:0]         ret_ff, ret_in;
   logic [7:0]         char_ff, char_in;
   logic               fin_ff, fin_in;
   op_code_type        op_ff, op_in;
   logic               close_mode_ff, close_mode_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   op_code_type        top_ff, top_in;
   logic               discard_ff, discard_in;

   // One result is held back until we know whether another follows it.
   logic               pend_valid_ff, pend_valid_in;
   logic [7:0]         pend_char_ff, pend_char_in;
   kind_type           pend_kind_ff, pend_kind_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_char_ff, rsp_char_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               can_emit;
   logic               flush_idle;
   logic               accept;
   logic               emit_en;
   logic [7:0]         emit_char;
   kind_type           emit_kind;
   logic               err_en;
   kind_type           err_kind;
   logic               mem_we;
   op_code_type        mem_wdata;
   logic               mem_re;
   op_code_type        mem_rdata;
   logic [DEPTH_W-1:0] depth_m2;
   op_code_type        dec_op;

   itp_stack_mem #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (depth_ff[ADDR_W-1:0]),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (depth_m2[ADDR_W-1:0]),
      .rd_data (mem_rdata)
   );

   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign can_emit   = !pend_valid_ff || out_free;
   assign flush_idle = (state_ff == S_IDLE) && pend_valid_ff && out_free;
   assign accept     = req_if.valid && req_if.ready;
   assign depth_m2   = depth_ff - DEPTH_TWO;   // new top index after a pop
   assign dec_op     = op_of_char(char_ff);

   assign req_if.ready = (state_ff == S_IDLE) && can_emit;

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.out_character = rsp_char_ff;
   assign rsp_if.kind          = rsp_kind_ff;
   assign rsp_if.last_of_run   = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      char_in       = char_ff;
      fin_in        = fin_ff;
      op_in         = op_ff;
      close_mode_in = close_mode_ff;
      depth_in      = depth_ff;
      top_in        = top_ff;
      discard_in    = discard_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      pend_kind_in  = pend_kind_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_last_in   = rsp_last_ff;
      emit_en       = 1'b0;
      emit_char     = CH_NONE;
      emit_kind     = KIND_CHAR;
      err_en        = 1'b0;
      err_kind      = KIND_CHAR;
      mem_we        = 1'b0;
      mem_wdata     = OP_OPEN;
      mem_re        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               char_in = req_if.character;
               fin_in  = req_if.final_item;
               if (discard_ff) begin
                  // swallow the word; the final one re-arms the block
                  if (req_if.final_item) begin
                     depth_in   = DEPTH_ONE;
                     top_in     = OP_OPEN;
                     discard_in = 1'b0;
                  end
               end else begin
                  state_in = S_DECODE;
               end
            end
         end

         S_DECODE: begin
            if (can_emit) begin
               if (fin_ff && (char_ff == CH_NONE)) begin
                  close_mode_in = 1'b1;
                  state_in      = S_POP;
               end else if (is_alnum(char_ff)) begin
                  emit_en       = 1'b1;
                  emit_char     = char_ff;
                  close_mode_in = 1'b1;
                  state_in      = fin_ff ? S_POP : S_IDLE;
               end else if (char_ff == CH_OPEN) begin
                  if (depth_ff == DEPTH_FULL) begin
                     err_en   = 1'b1;
                     err_kind = KIND_OVERFLOW;
                  end else begin
                     mem_we        = 1'b1;
                     mem_wdata     = OP_OPEN;
                     top_in        = OP_OPEN;
                     depth_in      = depth_ff + DEPTH_ONE;
                     close_mode_in = 1'b1;
                     state_in      = fin_ff ? S_POP : S_IDLE;
                  end
               end else if (dec_op != OP_OPEN) begin
                  op_in    = dec_op;
                  state_in = S_OPPOP;
               end else if (char_ff == CH_CLOSE) begin
                  close_mode_in = 1'b0;
                  state_in      = S_POP;
               end else begin
                  err_en   = 1'b1;
                  err_kind = KIND_BAD;
               end
            end
         end

         S_OPPOP: begin
            if (can_emit) begin
               if ((top_ff != OP_OPEN) && (prec_of_op(top_ff) >= prec_of_op(op_ff))) begin
                  emit_en   = 1'b1;
                  emit_char = char_of_op(top_ff);
                  depth_in  = depth_ff - DEPTH_ONE;
                  mem_re    = 1'b1;
                  ret_in    = S_OPPOP;
                  state_in  = S_WAIT;
               end else if (depth_ff == DEPTH_FULL) begin
                  err_en   = 1'b1;
                  err_kind = KIND_OVERFLOW;
               end else begin
                  mem_we        = 1'b1;
                  mem_wdata     = op_ff;
                  top_in        = op_ff;
                  depth_in      = depth_ff + DEPTH_ONE;
                  close_mode_in = 1'b1;
                  state_in      = fin_ff ? S_POP : S_IDLE;
               end
            end
         end

         S_POP: begin
            if (can_emit) begin
               depth_in = depth_ff - DEPTH_ONE;
               if (top_ff != OP_OPEN) begin
                  emit_en   = 1'b1;
                  emit_char = char_of_op(top_ff);
                  mem_re    = 1'b1;
                  ret_in    = S_POP;
                  state_in  = S_WAIT;
               end else if (depth_ff == DEPTH_ONE) begin
                  // reached the implicit bottom '('
                  err_en   = 1'b1;
                  err_kind = close_mode_ff ? KIND_END : KIND_CLOSE;
               end else if (close_mode_ff) begin
                  err_en   = 1'b1;
                  err_kind = KIND_OPEN;
               end else begin
                  // ')' matched; a final word still has to close the bottom
                  mem_re        = 1'b1;
                  close_mode_in = 1'b1;
                  ret_in        = fin_ff ? S_POP : S_IDLE;
                  state_in      = S_WAIT;
               end
            end
         end

         S_WAIT: begin
            top_in   = (depth_ff == DEPTH_ONE) ? OP_OPEN : mem_rdata;
            state_in = ret_ff;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // error or end word: emit it, then restart or start discarding
      if (err_en) begin
         emit_en   = 1'b1;
         emit_char = CH_NONE;
         emit_kind = err_kind;
         state_in  = S_IDLE;
         if (fin_ff || (err_kind == KIND_END)) begin
            depth_in   = DEPTH_ONE;
            top_in     = OP_OPEN;
            discard_in = 1'b0;
         end else begin
            discard_in = 1'b1;
         end
      end

      // advance the held result into the output register
      if (flush_idle) begin
         rsp_valid_in  = 1'b1;
         rsp_char_in   = pend_char_ff;
         rsp_kind_in   = pend_kind_ff;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end else if (emit_en && pend_valid_ff) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = pend_char_ff;
         rsp_kind_in  = pend_kind_ff;
         rsp_last_in  = 1'b0;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (emit_en) begin
         pend_valid_in = 1'b1;
         pend_char_in  = emit_char;
         pend_kind_in  = emit_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= S_IDLE;
         close_mode_ff <= 1'b0;
         depth_ff      <= DEPTH_ONE;
         top_ff        <= OP_OPEN;
         discard_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         close_mode_ff <= close_mode_in;
         depth_ff      <= depth_in;
         top_ff        <= top_in;
         discard_ff    <= discard_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      fin_ff       <= fin_in;
      op_ff        <= op_in;
      pend_char_ff <= pend_char_in;
      pend_kind_ff <= pend_kind_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // push and pop never touch the RAM in the same cycle
   `ITP_ASSERT_NOW(a_no_rw_overlap, mem_we, !mem_re)
   // a new result displaces the held one only into a free output register
   `ITP_ASSERT_NOW(a_no_dropped_result, emit_en && pend_valid_ff, out_free)
   // the implicit bottom stays on the stack of a live expression
   `ITP_ASSERT_NOW(a_bottom_kept, (state_ff == S_IDLE) && !discard_ff, depth_ff != '0)
   // every RAM read is followed by the top refill
   `ITP_ASSERT_NEXT(a_read_then_wait, mem_re, state_ff == S_WAIT)

endmodule

FILE: tb/itp_postfix_checker.sv
// Checker for the infix to postfix converter: predicts postfix words and compares them.
module itp_postfix_checker
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_character,
   input  logic       req_final_item,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_character,
   input  logic [2:0] rsp_kind,
   input  logic       rsp_last_of_run,
   output int         error_count,
   output int         pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] symbol;
      kind_type   kind;
      logic       closes_run;
   } postfix_word_type;

   postfix_word_type expected_words[$];
   op_code_type      op_stack[STACK_DEPTH];
   int unsigned      stack_fill;
   bit               swallowing;
   int               mismatches = 0;

   function automatic void clear_stack();
      op_stack[0] = OP_OPEN;
      stack_fill  = 1;
      swallowing  = 1'b0;
   endfunction

   function automatic op_code_type code_of(input logic [7:0] c);
      case (c)
         CH_PLUS:  return OP_PLUS;
         CH_MINUS: return OP_MINUS;
         CH_MUL:   return OP_MUL;
         CH_DIV:   return OP_DIV;
         CH_POW:   return OP_POW;
         default:  return OP_OPEN;
      endcase
   endfunction

   function automatic int rank_of(input op_code_type code);
      case (code)
         OP_PLUS, OP_MINUS: return 1;
         OP_MUL, OP_DIV:    return 2;
         OP_POW:            return 3;
         default:           return 0;
      endcase
   endfunction

   function automatic logic [7:0] symbol_of(input op_code_type code);
      case (code)
         OP_PLUS:  return CH_PLUS;
         OP_MINUS: return CH_MINUS;
         OP_MUL:   return CH_MUL;
         OP_DIV:   return CH_DIV;
         OP_POW:   return CH_POW;
         default:  return CH_OPEN;
      endcase
   endfunction

   function automatic void queue_word(input logic [7:0] symbol, input kind_type kind);
      postfix_word_type w;
      w.symbol     = symbol;
      w.kind       = kind;
      w.closes_run = 1'b0;
      expected_words.push_back(w);
   endfunction

   // Pop and emit operators down to the next '(' and drop it; return the slot it held.
   function automatic int unsigned unwind_to_open();
      op_code_type code;
      while (stack_fill > 0) begin
         code = op_stack[stack_fill - 1];
         stack_fill--;
         if (code == OP_OPEN) return stack_fill;
         queue_word(symbol_of(code), KIND_CHAR);
      end
      return 0;
   endfunction

   function automatic void predict_postfix(input logic [7:0] c, input logic fin);
      int unsigned queued_before;
      kind_type    fault;
      op_code_type op;
      op_code_type top;
      queued_before = expected_words.size();
      fault = KIND_CHAR;
      op = code_of(c);
      if (swallowing) begin
         if (fin) clear_stack();
         return;
      end
      if (!(fin && c == CH_NONE)) begin
         if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
            queue_word(c, KIND_CHAR);
         end else if (c == CH_OPEN) begin
            if (stack_fill >= STACK_DEPTH) begin
               fault = KIND_OVERFLOW;
            end else begin
               op_stack[stack_fill] = OP_OPEN;
               stack_fill++;
            end
         end else if (op != OP_OPEN) begin
            while (stack_fill > 0) begin
               top = op_stack[stack_fill - 1];
               if (top == OP_OPEN || rank_of(top) < rank_of(op)) break;
               queue_word(symbol_of(top), KIND_CHAR);
               stack_fill--;
            end
            if (stack_fill >= STACK_DEPTH) begin
               fault = KIND_OVERFLOW;
            end else begin
               op_stack[stack_fill] = op;
               stack_fill++;
            end
         end else if (c == CH_CLOSE) begin
            if (unwind_to_open() == 0) fault = KIND_CLOSE;
         end else begin
            fault = KIND_BAD;
         end
      end
      if (fault == KIND_CHAR && fin) fault = (unwind_to_open() != 0) ? KIND_OPEN : KIND_END;
      if (fault != KIND_CHAR) begin
         queue_word(CH_NONE, fault);
         if (fin) clear_stack();
         else swallowing = 1'b1;
      end
      if (expected_words.size() > queued_before)
         expected_words[expected_words.size() - 1].closes_run = 1'b1;
   endfunction

   always @(posedge clock) begin
      postfix_word_type got;
      postfix_word_type want;
      if (reset) begin
         expected_words.delete();
         clear_stack();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.symbol     = rsp_out_character;
            got.kind       = rsp_kind;
            got.closes_run = rsp_last_of_run;
            if (expected_words.size() == 0) begin
               mismatches++;
               $display("%0t itp check: unexpected word, expected none, %s %h kind %0d last %b",
                        $time, "got char", got.symbol, got.kind, got.closes_run);
            end else begin
               want = expected_words.pop_front();
               if (got.symbol !== want.symbol || got.kind !== want.kind ||
                   got.closes_run !== want.closes_run) begin
                  mismatches++;
                  $display("%0t itp check: expected char %h kind %0d last %b, %s",
                           $time, want.symbol, want.kind, want.closes_run, "got");
                  $display("   char %h kind %0d last %b",
                           got.symbol, got.kind, got.closes_run);
               end
            end
         end
         if (req_valid && req_ready) predict_postfix(req_character, req_final_item);
      end
      error_count   <= mismatches;
      pending_words <= expected_words.size();
   end

endmodule

FILE: tb/tb.sv
// Top of the converter testbench: clock, reset, stimulus, back-pressure and the verdict.
module tb
   import itp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 32;
   localparam int WORD_TARGET = 275;   // directed plus random input words

   typedef enum {SEQ_NOISE, SEQ_DEEP, SEQ_BROKEN, SEQ_CLEAN} seq_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   itp_char_if req_if();
   itp_rslt_if rsp_if();

   int error_count;
   int pending_words;

   int         words_sent = 0;
   bit         idle_on = 1'b1;
   logic [7:0] expr_chars[$];

   // Free-running clock, 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   infix_to_postfix_converter_unit #(.STACK_DEPTH(DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   itp_postfix_checker #(.STACK_DEPTH(DEPTH)) u_postfix_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_if.valid),
      .req_ready         (req_if.ready),
      .req_character     (req_if.character),
      .req_final_item    (req_if.final_item),
      .rsp_valid         (rsp_if.valid),
      .rsp_ready         (rsp_if.ready),
      .rsp_out_character (rsp_if.out_character),
      .rsp_kind          (rsp_if.kind),
      .rsp_last_of_run   (rsp_if.last_of_run),
      .error_count       (error_count),
      .pending_words     (pending_words)
   );

   // Offer one word from the falling edge; hold it until the block takes it at a rising edge.
   // Leave valid high afterwards so back-to-back words need no extra edge.
   task automatic send_word(input logic [7:0] c, input logic fin);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.character  <= c;
      req_if.final_item <= fin;
      do @(posedge clock); while (!req_if.ready);
      words_sent++;
      @(negedge clock);
   endtask

   // Send the queued expression; either flag its last character as final or close it
   // with an extra end-only word carrying character 0.
   task automatic send_expression(input bit null_end);
      int n;
      n = expr_chars.size();
      for (int i = 0; i < n; i++) send_word(expr_chars[i], !null_end && i == n - 1);
      if (null_end || n == 0) send_word(CH_NONE, 1'b1);
      expr_chars.delete();
   endtask

   task automatic load_text(input string s);
      for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
   endtask

   function automatic logic [7:0] pick_operand();
      case ($urandom_range(0, 2))
         0:       return 8'("0" + $urandom_range(0, 9));
         1:       return 8'("A" + $urandom_range(0, 25));
         default: return 8'("a" + $urandom_range(0, 25));
      endcase
   endfunction

   function automatic logic [7:0] pick_operator();
      case ($urandom_range(0, 4))
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         2:       return CH_MUL;
         3:       return CH_DIV;
         default: return CH_POW;
      endcase
   endfunction

   // Result side: random stall bursts, one long hold-off while the sender keeps going,
   // and always ready once idling is switched off near the end.
   initial begin
      bit held_off;
      held_off     = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && words_sent >= 80) begin
            // Hold off long enough for the block to back up and stall its input.
            held_off = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (300) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      seq_kind_type kind;
      bit           paused;
      bit           first_seq;
      int           opens;
      int           operands;
      int           pos;
      int           nest;
      int unsigned  drain_cycles;
      paused            = 1'b0;
      first_seq         = 1'b1;
      req_if.valid      = 1'b0;
      req_if.character  = CH_NONE;
      req_if.final_item = 1'b0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: every operator and precedence level in one run.
      load_text("a+b*c-d/e^f");
      send_expression(1'b0);
      // A ')' that closes the implicit bottom.
      load_text("a)");
      send_expression(1'b0);
      // Bad character mid-expression, then the rest is swallowed.
      load_text("#x");
      send_expression(1'b0);
      // Leftover '(' at the end.
      load_text("(0");
      send_expression(1'b0);
      // Character 0 on a non-final word is bad; end with an end-only word.
      send_word(CH_NONE, 1'b0);
      send_word(CH_NONE, 1'b1);
      // Top character code on a final word.
      send_word(8'hFF, 1'b1);
      // Plain operand closed by an end-only word.
      load_text("Z");
      send_expression(1'b1);

      // Random part: mostly well-formed expressions with random content.
      while (words_sent < WORD_TARGET) begin
         if (!paused && words_sent >= 170) begin
            // Drop valid and wait for every outstanding word before going on.
            paused = 1'b1;
            req_if.valid <= 1'b0;
            while (pending_words != 0) @(posedge clock);
            @(negedge clock);
         end
         if (words_sent >= 250) idle_on = 1'b0;

         if (first_seq) begin
            kind = SEQ_DEEP;
         end else begin
            case ($urandom_range(0, 19))
               0, 1:    kind = SEQ_NOISE;
               2:       kind = SEQ_DEEP;
               3, 4, 5: kind = SEQ_BROKEN;
               default: kind = SEQ_CLEAN;
            endcase
         end
         first_seq = 1'b0;

         case (kind)
            SEQ_NOISE: begin
               repeat ($urandom_range(1, 6)) expr_chars.push_back(8'($urandom_range(0, 255)));
            end
            SEQ_DEEP: begin
               // Nest around the stack limit: some runs overflow, some just fit.
               nest = $urandom_range(28, 34);
               repeat (nest) expr_chars.push_back(CH_OPEN);
               expr_chars.push_back(pick_operand());
               expr_chars.push_back(pick_operator());
               expr_chars.push_back(pick_operand());
               repeat (nest) expr_chars.push_back(CH_CLOSE);
            end
            default: begin
               opens    = 0;
               operands = $urandom_range(1, 6);
               for (int k = 0; k < operands; k++) begin
                  while (opens < 4 && $urandom_range(0, 3) == 0) begin
                     expr_chars.push_back(CH_OPEN);
                     opens++;
                  end
                  expr_chars.push_back(pick_operand());
                  while (opens > 0 && $urandom_range(0, 2) == 0) begin
                     expr_chars.push_back(CH_CLOSE);
                     opens--;
                  end
                  if (k < operands - 1) expr_chars.push_back(pick_operator());
               end
               repeat (opens) expr_chars.push_back(CH_CLOSE);
               if (kind == SEQ_BROKEN) begin
                  // Corrupt one spot: a stray byte or an unbalanced parenthesis.
                  pos = $urandom_range(0, expr_chars.size() - 1);
                  case ($urandom_range(0, 2))
                     0:       expr_chars[pos] = 8'($urandom_range(0, 255));
                     1:       expr_chars.insert(pos, CH_CLOSE);
                     default: expr_chars.insert(pos, CH_OPEN);
                  endcase
               end
            end
         endcase
         send_expression(1'($urandom_range(0, 1)));
      end

      // Drain: drop valid, wait for the last expected word, then let the block settle.
      req_if.valid <= 1'b0;
      drain_cycles = 0;
      while (pending_words != 0 && drain_cycles < 100000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (80) @(posedge clock);

      if (pending_words == 0 && error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #4000000;
      $display("tb: errors");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/itp_pkg.sv
sv/itp_intf.sv
sv/itp_stack_mem.sv
sv/infix_to_postfix_converter_unit.sv
tb/itp_postfix_checker.sv
tb/tb.sv
